// File: rtl/lcs_pkg.sv
// Package: item types and sequencer states of the LCS traceback block.
`default_nettype none
package lcs_pkg;

  typedef enum logic [1:0] {
    FUNC_APPEND_A = 2'd0,
    FUNC_APPEND_B = 2'd1,
    FUNC_START    = 2'd2,
    FUNC_NONE     = 2'd3
  } func_e;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] char_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic [6:0] lcs_length;
    logic       empty_res;
    logic       last;
    logic       overflow;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROW,
    ST_FRD,
    ST_FWR,
    ST_TRD,
    ST_TUP,
    ST_TEV,
    ST_ORD,
    ST_OLD
  } state_e;

endpackage
`default_nettype wire

// File: rtl/lcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lcs_ram #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 64,
  localparam int unsigned AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [W-1:0]  wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [W-1:0]  rdata_o
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule
`default_nettype wire

// File: rtl/lcs_dp_traceback.sv
// Top level: LCS length-matrix fill and traceback over two loaded strings.
`default_nettype none
// Characters are appended one item per cycle (func 0 to the first string, func 1 to the
// second); past MAX_LEN they are dropped and the overflow flag is raised for the run. A
// start item (func 2) stalls the input until the result is out. The matrix fills over
// n1*n2 cells in states FRD and FWR, with a ROW state per row to fetch the row character,
// then traces back in states TRD, TUP and TEV (at most n1+n2 steps), then emits one item
// per subsequence character through states ORD and OLD; an empty result gives a single
// item with empty_res set; the matrix RAM has a single read port. The matrix border
// is never stored: row 0 and column 0 read as zero through the datapath.
module lcs_dp_traceback
  import lcs_pkg::*;
#(
  parameter int unsigned MAX_LEN = 64
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_item_o
);
  localparam int unsigned DIM = MAX_LEN + 1;
  localparam int unsigned MD  = DIM * DIM;
  localparam int unsigned CW  = $clog2(MAX_LEN + 1);
  localparam int unsigned IW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned AW  = $clog2(MD);

  state_e state_q, state_d;
  logic [CW-1:0] n1_q, n1_d, n2_q, n2_d, r_q, r_d, c_q, c_d;
  logic [CW-1:0] diag_q, diag_d, left_q, left_d, here_q, here_d;
  logic [CW-1:0] pos_q, pos_d, oi_q, oi_d;
  logic [AW-1:0] rb_q, rb_d;
  logic          ovf_q, ovf_d, ov_q, ov_d;
  out_item_t     out_q, out_d;

  // memory ports
  logic          a_we, b_we, a_re, b_re, m_we, m_re, u_we, u_re;
  logic [IW-1:0] a_wa, b_wa, a_ra, b_ra, u_wa, u_ra;
  logic [AW-1:0] m_wa, m_ra;
  logic [7:0]    a_rd, b_rd, u_rd, u_wd;
  logic [CW-1:0] m_wd, m_rd;

  lcs_ram #(.W(8), .D(MAX_LEN)) u_str_a (
    .clk_i, .we_i(a_we), .waddr_i(a_wa), .wdata_i(in_item_i.char_in),
    .re_i(a_re), .raddr_i(a_ra), .rdata_o(a_rd));
  lcs_ram #(.W(8), .D(MAX_LEN)) u_str_b (
    .clk_i, .we_i(b_we), .waddr_i(b_wa), .wdata_i(in_item_i.char_in),
    .re_i(b_re), .raddr_i(b_ra), .rdata_o(b_rd));
  lcs_ram #(.W(CW), .D(MD)) u_matrix (
    .clk_i, .we_i(m_we), .waddr_i(m_wa), .wdata_i(m_wd),
    .re_i(m_re), .raddr_i(m_ra), .rdata_o(m_rd));
  lcs_ram #(.W(8), .D(MAX_LEN)) u_result (
    .clk_i, .we_i(u_we), .waddr_i(u_wa), .wdata_i(u_wd),
    .re_i(u_re), .raddr_i(u_ra), .rdata_o(u_rd));

  logic          in_acc, slot_free, match;
  logic [CW-1:0] up, best;
  logic [31:0]   len;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = ov_q;
  assign out_item_o  = out_q;
  assign slot_free   = !ov_q || !out_stall_i;
  assign match       = (a_rd == b_rd);
  assign len         = 32'(MAX_LEN) - 32'(pos_q);

  always_comb begin
    state_d = state_q;
    n1_d = n1_q; n2_d = n2_q; r_d = r_q; c_d = c_q;
    diag_d = diag_q; left_d = left_q; here_d = here_q;
    pos_d = pos_q; oi_d = oi_q; rb_d = rb_q; ovf_d = ovf_q;
    ov_d = ov_q && out_stall_i;
    out_d = out_q;
    a_we = 1'b0; b_we = 1'b0; a_re = 1'b0; b_re = 1'b0;
    m_we = 1'b0; m_re = 1'b0; u_we = 1'b0; u_re = 1'b0;
    a_wa = n1_q[IW-1:0]; b_wa = n2_q[IW-1:0];
    a_ra = r_q[IW-1:0];  b_ra = c_q[IW-1:0];
    m_wa = rb_q + AW'(DIM) + AW'(c_q) + AW'(1);
    m_ra = rb_q + AW'(c_q) + AW'(1);
    m_wd = '0;
    u_wa = IW'(pos_q - CW'(1)); u_wd = a_rd;
    u_ra = oi_q[IW-1:0];
    up   = '0;
    best = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_item_i.func)
            FUNC_APPEND_A: begin
              if (n1_q < CW'(MAX_LEN)) begin
                a_we = 1'b1;
                n1_d = n1_q + CW'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            FUNC_APPEND_B: begin
              if (n2_q < CW'(MAX_LEN)) begin
                b_we = 1'b1;
                n2_d = n2_q + CW'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            FUNC_START: begin
              pos_d = CW'(MAX_LEN);
              r_d   = '0;
              rb_d  = '0;
              if (n1_q == '0 || n2_q == '0) begin
                state_d = ST_ORD;
              end else begin
                state_d = ST_ROW;
              end
            end
            default: ;
          endcase
        end
      end
      ST_ROW: begin
        // fetch the row character; it stays in the read register for the whole row
        a_re    = 1'b1;
        c_d     = '0;
        diag_d  = '0;
        left_d  = '0;
        state_d = ST_FRD;
      end
      ST_FRD: begin
        b_re    = 1'b1;
        m_re    = 1'b1;
        state_d = ST_FWR;
      end
      ST_FWR: begin
        up   = (r_q == '0) ? '0 : m_rd;
        best = (up > left_q) ? up : left_q;
        m_wd = match ? diag_q + CW'(1) : best;
        m_we = 1'b1;
        diag_d = up;
        left_d = m_wd;
        if (c_q + CW'(1) == n2_q) begin
          r_d  = r_q + CW'(1);
          rb_d = rb_q + AW'(DIM);
          if (r_q + CW'(1) == n1_q) begin
            c_d     = n2_q;
            state_d = ST_TRD;
          end else begin
            state_d = ST_ROW;
          end
        end else begin
          c_d     = c_q + CW'(1);
          state_d = ST_FRD;
        end
      end
      ST_TRD: begin
        if (r_q == '0 || c_q == '0) begin
          oi_d    = pos_q;
          state_d = ST_ORD;
        end else begin
          a_re = 1'b1;
          b_re = 1'b1;
          m_re = 1'b1;
          a_ra = IW'(r_q - CW'(1));
          b_ra = IW'(c_q - CW'(1));
          m_ra = rb_q + AW'(c_q);
          state_d = ST_TUP;
        end
      end
      ST_TUP: begin
        here_d  = m_rd;
        m_re    = 1'b1;
        m_ra    = rb_q - AW'(DIM) + AW'(c_q);
        state_d = ST_TEV;
      end
      ST_TEV: begin
        up = (r_q == CW'(1)) ? '0 : m_rd;
        if (match) begin
          u_we  = 1'b1;
          pos_d = pos_q - CW'(1);
          r_d   = r_q - CW'(1);
          rb_d  = rb_q - AW'(DIM);
          c_d   = c_q - CW'(1);
        end else if (here_q == up) begin
          r_d  = r_q - CW'(1);
          rb_d = rb_q - AW'(DIM);
        end else begin
          c_d = c_q - CW'(1);
        end
        state_d = ST_TRD;
      end
      ST_ORD: begin
        oi_d    = pos_q;
        u_re    = (pos_q != CW'(MAX_LEN));
        u_ra    = pos_q[IW-1:0];
        if (oi_q != pos_q && state_q == ST_ORD) begin
          u_ra = oi_q[IW-1:0];
          oi_d = oi_q;
        end
        state_d = ST_OLD;
      end
      ST_OLD: begin
        if (slot_free) begin
          ov_d = 1'b1;
          out_d.overflow = ovf_q;
          if (pos_q == CW'(MAX_LEN)) begin
            out_d.char_out   = '0;
            out_d.lcs_length = '0;
            out_d.empty_res  = 1'b1;
            out_d.last       = 1'b1;
          end else begin
            out_d.char_out   = u_rd;
            out_d.lcs_length = len[6:0];
            out_d.empty_res  = 1'b0;
            out_d.last       = (oi_q == CW'(MAX_LEN - 1));
          end
          if (pos_q == CW'(MAX_LEN) || oi_q == CW'(MAX_LEN - 1)) begin
            n1_d    = '0;
            n2_d    = '0;
            ovf_d   = 1'b0;
            oi_d    = '0;
            pos_d   = '0;
            state_d = ST_IDLE;
          end else begin
            oi_d    = oi_q + CW'(1);
            state_d = ST_ORD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      n1_q    <= '0;
      n2_q    <= '0;
      ovf_q   <= 1'b0;
      ov_q    <= 1'b0;
      pos_q   <= '0;
      oi_q    <= '0;
    end else begin
      state_q <= state_d;
      n1_q    <= n1_d;
      n2_q    <= n2_d;
      ovf_q   <= ovf_d;
      ov_q    <= ov_d;
      pos_q   <= pos_d;
      oi_q    <= oi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q    <= r_d;
    c_q    <= c_d;
    rb_q   <= rb_d;
    diag_q <= diag_d;
    left_q <= left_d;
    here_q <= here_d;
    out_q  <= out_d;
  end
endmodule
`default_nettype wire

// File: rtl/lcs_chk.sv
// Port-level checker for the LCS traceback block, bound to the top level.
`default_nettype none
module lcs_chk
  import lcs_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire out_item_t out_item_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result item changed while stalled");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.empty_res |-> out_item_o.last)
    else $error("empty result not marked last");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.empty_res |->
      out_item_o.lcs_length == 7'd0 && out_item_o.char_out == 8'd0)
    else $error("empty result carries data");
endmodule

bind lcs_dp_traceback lcs_chk u_lcs_chk (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_item_o(out_item_o)
);
`default_nettype wire
